### design/ofpc_pkg.sv
// Package: shared types, codes and policy helper functions for the fail-safe controller.
`default_nettype none
package ofpc_pkg;

    localparam int unsigned LANE_COUNT  = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_REASON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ACTIONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_ACTIONS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ACTIONS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MASK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MASK    = 3'd7;

    // reason codes
    localparam logic [3:0] RSN_NONE         = 4'd0;
    localparam logic [3:0] RSN_BOOT         = 4'd1;
    localparam logic [3:0] RSN_COMM_LOSS    = 4'd2;
    localparam logic [3:0] RSN_FAULT        = 4'd3;
    localparam logic [3:0] RSN_WATCHDOG     = 4'd4;
    localparam logic [3:0] RSN_OFFLINE      = 4'd5;
    localparam logic [3:0] RSN_REVOKED      = 4'd6;
    localparam logic [3:0] RSN_UNAUTHORIZED = 4'd7;
    localparam logic [3:0] RSN_CFG_INVALID  = 4'd8;
    localparam logic [3:0] RSN_TEST         = 4'd9;

    // action codes
    localparam logic [2:0] ACT_OFF      = 3'd0;
    localparam logic [2:0] ACT_ON       = 3'd1;
    localparam logic [2:0] ACT_HOLD     = 3'd2;
    localparam logic [2:0] ACT_SNAPSHOT = 3'd3;
    localparam logic [2:0] ACT_SAFE     = 3'd4;

    typedef enum logic [1:0] {
        REQ_APPLY   = 2'd0,
        REQ_GUARD   = 2'd1,
        REQ_REARM   = 2'd2,
        REQ_STARTUP = 2'd3
    } t_req_e;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] output_index;
        logic [3:0] fault_reason;
        logic       value_in;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic       drive_value;
        logic       from_snapshot;
        logic       active_now;
        logic [3:0] reason_now;
        logic       last_value_now;
    } t_rsp;

    typedef struct packed {
        logic load_in;   // capture the input beat
        logic exec;      // update per-output state, load result register
    } t_dp_cmd;

    function automatic logic [2:0] act_code(input logic [CFG_DATA_W-1:0] packed_act,
                                            input logic [3:0] idx);
        logic [LANE_COUNT-1:0][2:0] lanes;
        lanes = packed_act;
        return lanes[idx];
    endfunction

    // reasons outside the classes fall back to hold
    function automatic logic [2:0] reason_action(input logic [3:0] reason,
                                                 input logic [2:0] boot_act,
                                                 input logic [2:0] comm_act,
                                                 input logic [2:0] fault_act);
        logic [2:0] act;
        case (reason) inside
            RSN_BOOT: act = boot_act;
            RSN_COMM_LOSS, RSN_OFFLINE, RSN_REVOKED, RSN_UNAUTHORIZED: act = comm_act;
            RSN_FAULT, RSN_WATCHDOG, RSN_CFG_INVALID, RSN_TEST: act = fault_act;
            default: act = ACT_HOLD;
        endcase
        return act;
    endfunction

    function automatic logic action_value(input logic [2:0] act, input logic value,
                                          input logic safe_bit);
        logic v;
        case (act) inside
            ACT_ON:                 v = 1'b1;
            ACT_HOLD, ACT_SNAPSHOT: v = value;
            ACT_SAFE:               v = safe_bit;
            default:                v = 1'b0;   // off, and the unused codes
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/ofpc_req_if.sv
// Interface: request channel (valid/ready plus request fields).
`default_nettype none
interface ofpc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] output_index;
    logic [3:0] fault_reason;
    logic       value_in;

    modport source (output valid, req_type, output_index, fault_reason, value_in,
                    input ready);
    modport sink (input valid, req_type, output_index, fault_reason, value_in,
                  output ready);
endinterface
`default_nettype wire

### design/ofpc_rsp_if.sv
// Interface: result channel (valid/ready plus result fields).
`default_nettype none
interface ofpc_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       drive_value;
    logic       from_snapshot;
    logic       active_now;
    logic [3:0] reason_now;
    logic       last_value_now;

    modport source (output valid, accepted, drive_value, from_snapshot, active_now,
                    reason_now, last_value_now, input ready);
    modport sink (input valid, accepted, drive_value, from_snapshot, active_now,
                  reason_now, last_value_now, output ready);
endinterface
`default_nettype wire

### design/ofpc_cfg_if.sv
// Interface: configuration write channel (valid/ready, register index, data).
`default_nettype none
interface ofpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/ofpc_ctrl.sv
// Controller: request sequencing (capture, execute) and result-valid tracking.
`default_nettype none
module ofpc_ctrl
    import ofpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state_e;

    t_state_e r_state, n_state;
    logic     r_out_valid, n_out_valid;
    logic     exec_ok;

    // result slot is free, or its beat leaves this cycle
    assign exec_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_ok) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### design/ofpc_datapath.sv
// Datapath: policy registers, per-output state stores and request evaluation.
`default_nettype none
module ofpc_datapath
    import ofpc_pkg::*;
#(
    parameter int unsigned OUTPUTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire t_req                  i_req,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_rsp                       o_rsp
);

    localparam int unsigned IW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;

    // policy registers
    logic [4:0]            r_out_count;
    logic [3:0]            r_boot_reason;
    logic [15:0]           r_enable;
    logic [CFG_DATA_W-1:0] r_boot_act;
    logic [CFG_DATA_W-1:0] r_comm_act;
    logic [CFG_DATA_W-1:0] r_fault_act;
    logic [15:0]           r_manual;
    logic [15:0]           r_safe;

    // per-output state
    logic       r_latch  [OUTPUTS];
    logic [3:0] r_reason [OUTPUTS];
    logic       r_value  [OUTPUTS];

    t_req r_req;
    t_rsp r_rsp;

    logic [3:0]    idx;
    logic [IW-1:0] ia;
    logic          found, en, man, safe_bit;
    logic          cur_latch, cur_value;
    logic [3:0]    cur_reason;
    logic [2:0]    act_apply, act_boot;
    logic          n_latch, n_value, wr_state;
    logic [3:0]    n_reason;
    t_rsp          n_rsp;

    assign idx      = r_req.output_index;
    assign ia       = idx[IW-1:0];
    assign found    = ({1'b0, idx} < r_out_count) && ({1'b0, idx} < 5'(OUTPUTS));
    assign en       = r_enable[idx];
    assign man      = r_manual[idx];
    assign safe_bit = r_safe[idx];

    assign cur_latch  = r_latch[ia];
    assign cur_reason = r_reason[ia];
    assign cur_value  = r_value[ia];

    assign act_apply = reason_action(r_req.fault_reason, act_code(r_boot_act, idx),
                                     act_code(r_comm_act, idx), act_code(r_fault_act, idx));
    assign act_boot  = reason_action(r_boot_reason, act_code(r_boot_act, idx),
                                     act_code(r_comm_act, idx), act_code(r_fault_act, idx));

    always_comb begin
        n_latch  = cur_latch;
        n_reason = cur_reason;
        n_value  = cur_value;
        n_rsp    = '0;
        case (t_req_e'(r_req.req_type))
            REQ_APPLY: begin
                if (en && (r_req.fault_reason inside {[RSN_BOOT:RSN_TEST]})) begin
                    n_rsp.accepted    = 1'b1;
                    n_rsp.drive_value = action_value(act_apply, r_req.value_in, safe_bit);
                    n_value           = n_rsp.drive_value;
                    n_reason          = r_req.fault_reason;
                    n_latch           = man;
                end
            end
            REQ_GUARD: begin
                n_rsp.drive_value = r_req.value_in;
                if (!(en && cur_latch && man)) begin
                    n_rsp.accepted = 1'b1;
                    n_value        = r_req.value_in;
                end
            end
            REQ_REARM: begin
                n_rsp.accepted = 1'b1;
                n_latch        = 1'b0;
                n_reason       = RSN_NONE;
            end
            default: begin
                n_rsp.accepted = 1'b1;
                if (!en) begin
                    n_rsp.drive_value   = r_req.value_in;
                    n_rsp.from_snapshot = 1'b1;
                    n_latch             = 1'b0;
                    n_reason            = RSN_NONE;
                end else begin
                    n_rsp.drive_value = action_value(act_boot, r_req.value_in, safe_bit);
                    n_reason          = r_boot_reason;
                    n_latch           = man;
                end
                n_value = n_rsp.drive_value;
            end
        endcase
        n_rsp.active_now     = n_latch;
        n_rsp.reason_now     = n_reason;
        n_rsp.last_value_now = n_value;
        if (!found) begin
            n_rsp = '0;
        end
    end

    assign wr_state = i_cmd.exec && found;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count   <= '0;
            r_boot_reason <= RSN_BOOT;
            r_enable      <= '1;
            r_boot_act    <= '0;
            r_comm_act    <= '0;
            r_fault_act   <= '0;
            r_manual      <= '0;
            r_safe        <= '0;
            for (int i = 0; i < OUTPUTS; i++) begin
                r_latch[i]  <= 1'b0;
                r_reason[i] <= RSN_NONE;
                r_value[i]  <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUTPUT_COUNT:  r_out_count   <= i_cfg_data[4:0];
                    CFG_BOOT_REASON:   r_boot_reason <= i_cfg_data[3:0];
                    CFG_ENABLE_MASK: begin
                        r_enable <= i_cfg_data[15:0];
                        // outputs losing their policy drop latch and reason
                        for (int i = 0; i < OUTPUTS; i++) begin
                            if (r_enable[i] && !i_cfg_data[i]) begin
                                r_latch[i]  <= 1'b0;
                                r_reason[i] <= RSN_NONE;
                            end
                        end
                    end
                    CFG_BOOT_ACTIONS:  r_boot_act  <= i_cfg_data;
                    CFG_COMM_ACTIONS:  r_comm_act  <= i_cfg_data;
                    CFG_FAULT_ACTIONS: r_fault_act <= i_cfg_data;
                    CFG_MANUAL_MASK:   r_manual    <= i_cfg_data[15:0];
                    CFG_SAFE_MASK:     r_safe      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (wr_state) begin
                r_latch[ia]  <= n_latch;
                r_reason[ia] <= n_reason;
                r_value[ia]  <= n_value;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

### design/output_failsafe_policy_controller.sv
// Top level: per-output fail-safe policy controller with request, result and config channels.
//
// Each request beat addresses one output and yields exactly one result beat. A request
// is first captured, then evaluated: the policy is applied and that output's latch,
// reason and last value are updated; the input side is ready again right after, so a
// new request is captured only once the last one is evaluated. The result sits in an output
// register, and a new request is captured while it waits; evaluation of that request
// holds until the result register is taken. The configuration port is always ready and
// must only be written while no request is in flight. Indexes at or above output_count
// (or OUTPUTS) are refused with an all-zero result.
`default_nettype none
module output_failsafe_policy_controller
    import ofpc_pkg::*;
#(
    parameter int unsigned OUTPUTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ofpc_req_if.sink   i_req,
    ofpc_rsp_if.source o_rsp,
    ofpc_cfg_if.sink   i_cfg
);

    t_dp_cmd cmd;
    t_req    req;
    t_rsp    rsp;
    logic    cfg_we;

    assign req.req_type     = i_req.req_type;
    assign req.output_index = i_req.output_index;
    assign req.fault_reason = i_req.fault_reason;
    assign req.value_in     = i_req.value_in;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    ofpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    ofpc_datapath #(
        .OUTPUTS (OUTPUTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (req),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_rsp       (rsp)
    );

    assign o_rsp.accepted       = rsp.accepted;
    assign o_rsp.drive_value    = rsp.drive_value;
    assign o_rsp.from_snapshot  = rsp.from_snapshot;
    assign o_rsp.active_now     = rsp.active_now;
    assign o_rsp.reason_now     = rsp.reason_now;
    assign o_rsp.last_value_now = rsp.last_value_now;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request side ready in the cycle after a capture");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

    a_snapshot_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.from_snapshot |-> o_rsp.accepted && !o_rsp.active_now
            && (o_rsp.reason_now == RSN_NONE) && (o_rsp.drive_value == o_rsp.last_value_now))
        else $error("snapshot startup result with inconsistent state fields");

    a_refused_no_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.accepted |-> !o_rsp.from_snapshot)
        else $error("refused result flagged as snapshot");
`endif

endmodule
`default_nettype wire
